// File: hw/rtl/rhq_pkg.sv
package rhq_pkg;

   localparam int LAT_W  = 28;
   localparam int LON_W  = 29;
   localparam int HEAD_W = 31;
   localparam int QUAT_W = 32;

   // cordic datapath widths
   localparam int XY_W = 64;
   localparam int Z_W  = 36;
   localparam int SC_W = 34;
   localparam int P_W  = 2 * SC_W;

   localparam logic signed [XY_W-1:0] GAIN_Q30 = 64'sd652032874;
   localparam logic signed [Z_W-1:0]  PI_Q30   = 36'sd3373259426;
   localparam logic signed [XY_W-1:0] ONE_Q30  = 64'sd1073741824;
   localparam logic signed [SC_W-1:0] DEG_Q32  = 34'sd74961321;

   typedef logic signed [LAT_W-1:0]  lat_type;
   typedef logic signed [LON_W-1:0]  lon_type;
   typedef logic signed [HEAD_W-1:0] head_type;
   typedef logic signed [QUAT_W-1:0] quat_type;

   // atan(2^-i) in Q30
   function automatic logic signed [Z_W-1:0] step_angle(input logic [5:0] i);
      logic signed [Z_W-1:0] a;
      case (i)
         6'd0:    a = 36'sh03243F6A8;
         6'd1:    a = 36'sh01DAC6705;
         6'd2:    a = 36'sh00FADBAFC;
         6'd3:    a = 36'sh007F56EA6;
         6'd4:    a = 36'sh003FEAB76;
         6'd5:    a = 36'sh001FFD55B;
         6'd6:    a = 36'sh000FFFAAA;
         6'd7:    a = 36'sh0007FFF55;
         6'd8:    a = 36'sh0003FFFEA;
         6'd9:    a = 36'sh0001FFFFD;
         default: a = (i <= 6'd30) ? (36'sd1 <<< (6'd30 - i)) : '0;
      endcase
      return a;
   endfunction

endpackage

// File: hw/rtl/rhq_req_if.sv
interface rhq_req_if;
   import rhq_pkg::*;
   logic    valid;
   logic    ready;
   logic    start_of_route;
   lat_type latitude;
   lon_type longitude;
   modport source (output valid, start_of_route, latitude, longitude, input ready);
   modport sink   (input valid, start_of_route, latitude, longitude, output ready);
endinterface

// File: hw/rtl/rhq_rsp_if.sv
interface rhq_rsp_if;
   import rhq_pkg::*;
   logic     valid;
   logic     ready;
   head_type heading;
   quat_type quat_z;
   quat_type quat_w;
   modport source (output valid, heading, quat_z, quat_w, input ready);
   modport sink   (input valid, heading, quat_z, quat_w, output ready);
endinterface

// File: hw/rtl/route_heading_quaternion_top.sv
// a route-start beat, or a beat with no stored waypoint, is only stored and gives no result
// throughput: one beat at a time; the single shared cordic does up to five passes per beat
// (three sine/cosine, one vectoring atan2 unless both terms are zero, one quaternion rotation)
// reset: synchronous, active high; clears the sequencer, the stored waypoint flag and rsp valid
module route_heading_quaternion_top #(
   parameter int CORDIC_ITERATIONS   = 32,
   parameter int ANGLE_FRACTION_BITS = 20
) (
   input logic        clock,
   input logic        reset,
   rhq_req_if.sink    req_chan,
   rhq_rsp_if.source  rsp_chan
);
   import rhq_pkg::*;

   localparam int IT_W  = $clog2(CORDIC_ITERATIONS);
   localparam int RED_W = 46;
   localparam int RED_K = 10;   // full turn << 10 exceeds any input difference

   localparam longint HALF_L = 64'sd180 <<< ANGLE_FRACTION_BITS;
   localparam logic signed [RED_W-1:0] HALF_R    = RED_W'(HALF_L);
   localparam logic signed [RED_W-1:0] FULL_R    = RED_W'(2 * HALF_L);
   localparam logic signed [RED_W-1:0] QUARTER_R = RED_W'(HALF_L / 2);
   localparam logic signed [RED_W-1:0] RED_OFS   = RED_W'(2 * HALF_L) <<< RED_K;
   localparam logic signed [P_W-1:0]   DEG_RND   = P_W'(1) <<< (ANGLE_FRACTION_BITS + 1);
   localparam logic [IT_W-1:0]         IT_LAST   = IT_W'(CORDIC_ITERATIONS - 1);

   // sequencer states
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_LOAD  = 5'd1;
   localparam logic [4:0] S_RED   = 5'd2;
   localparam logic [4:0] S_FOLD  = 5'd3;
   localparam logic [4:0] S_MUL   = 5'd4;
   localparam logic [4:0] S_RINIT = 5'd5;
   localparam logic [4:0] S_ROT   = 5'd6;
   localparam logic [4:0] S_STORE = 5'd7;
   localparam logic [4:0] S_P0    = 5'd8;
   localparam logic [4:0] S_P1    = 5'd9;
   localparam logic [4:0] S_P2    = 5'd10;
   localparam logic [4:0] S_P3    = 5'd11;
   localparam logic [4:0] S_P4    = 5'd12;
   localparam logic [4:0] S_VINIT = 5'd13;
   localparam logic [4:0] S_VEC   = 5'd14;
   localparam logic [4:0] S_QINIT = 5'd15;
   localparam logic [4:0] S_OUT   = 5'd16;

   // which angle the sine/cosine pass works on
   localparam logic [1:0] SEL_LAT1 = 2'd0;
   localparam logic [1:0] SEL_LAT2 = 2'd1;
   localparam logic [1:0] SEL_DLON = 2'd2;

   logic [4:0] state_ff, state_in;
   logic       have_prev_ff, have_prev_in;
   lat_type    prev_lat_ff, prev_lat_in, cur_lat_ff, cur_lat_in;
   lon_type    prev_lon_ff, prev_lon_in, cur_lon_ff, cur_lon_in;
   logic [1:0] sel_ff, sel_in;
   logic [3:0] k_ff, k_in;
   logic signed [RED_W-1:0] red_ff, red_in;
   logic       neg_ff, neg_in;
   logic       quat_ff, quat_in;
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]  z_ff, z_in, yaw_ff, yaw_in;
   logic [IT_W-1:0] it_ff, it_in;
   logic signed [P_W-1:0]  prod_ff, prod_in;
   logic signed [SC_W-1:0] s1_ff, s1_in, c1_ff, c1_in, s2_ff, s2_in, c2_ff, c2_in;
   logic signed [SC_W-1:0] sd_ff, sd_in, cd_ff, cd_in, t_ff, t_in, ya_ff, ya_in, xa_ff, xa_in;
   logic signed [P_W-1:0]  m3_ff, m3_in;
   logic       rsp_valid_ff, rsp_valid_in;
   head_type   heading_ff, heading_in;
   quat_type   qz_ff, qz_in, qw_ff, qw_in;

   // shared multiplier operands
   logic signed [SC_W-1:0] mul_a, mul_b;
   // shared cordic step
   logic signed [XY_W-1:0] sx, sy;
   logic signed [Z_W-1:0]  ang;
   logic                   pos;
   logic signed [XY_W-1:0] nx, ny;
   logic signed [Z_W-1:0]  nz;
   // reduction and fold helpers
   logic signed [LON_W:0]   dlon;
   logic signed [RED_W-1:0] d_ext, red_step, fr;
   logic signed [P_W:0]     xdiff;
   logic signed [Z_W-1:0]   ysat;
   logic signed [XY_W-1:0]  sv, cv, zs, ws;
   logic signed [Z_W-1:0]  head_r;

   logic req_fire;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.heading = heading_ff;
   assign rsp_chan.quat_z  = qz_ff;
   assign rsp_chan.quat_w  = qw_ff;

   // multiplier input selection by sequencer step
   always_comb begin
      case (state_ff)
         S_MUL: begin
            mul_a = SC_W'(red_ff);
            mul_b = DEG_Q32;
         end
         S_P0: begin
            mul_a = sd_ff;
            mul_b = c2_ff;
         end
         S_P1: begin
            mul_a = s1_ff;
            mul_b = c2_ff;
         end
         S_P2: begin
            mul_a = c1_ff;
            mul_b = s2_ff;
         end
         S_P3: begin
            mul_a = t_ff;
            mul_b = cd_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // one cordic micro-rotation, rotation mode or vectoring mode
   always_comb begin
      sx  = x_ff >>> it_ff;
      sy  = y_ff >>> it_ff;
      ang = step_angle(6'(it_ff));
      pos = (state_ff == S_VEC) ? y_ff[XY_W-1] : !z_ff[Z_W-1];
      if (pos) begin
         nx = x_ff - sy;
         ny = y_ff + sx;
         nz = z_ff - ang;
      end else begin
         nx = x_ff + sy;
         ny = y_ff - sx;
         nz = z_ff + ang;
      end
   end

   always_comb begin
      dlon     = (LON_W+1)'(cur_lon_ff) - (LON_W+1)'(prev_lon_ff);
      case (sel_ff)
         SEL_LAT1: d_ext = RED_W'(prev_lat_ff);
         SEL_LAT2: d_ext = RED_W'(cur_lat_ff);
         default:  d_ext = RED_W'(dlon);
      endcase
      red_step = FULL_R <<< k_ff;
      fr       = (red_ff >= HALF_R) ? red_ff - FULL_R : red_ff;
      xdiff    = (P_W+1)'(m3_ff) - (P_W+1)'(prod_ff);
      ysat     = (z_ff > PI_Q30) ? PI_Q30 : ((z_ff < -PI_Q30) ? -PI_Q30 : z_ff);
      sv       = neg_ff ? -y_ff : y_ff;
      cv       = neg_ff ? -x_ff : x_ff;
      zs       = (y_ff > ONE_Q30) ? ONE_Q30 : ((y_ff < -ONE_Q30) ? -ONE_Q30 : y_ff);
      ws       = (x_ff > ONE_Q30) ? ONE_Q30 : ((x_ff < -ONE_Q30) ? -ONE_Q30 : x_ff);
      head_r   = (yaw_ff + Z_W'(2)) >>> 2;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      prev_lat_in  = prev_lat_ff;
      prev_lon_in  = prev_lon_ff;
      cur_lat_in   = cur_lat_ff;
      cur_lon_in   = cur_lon_ff;
      sel_in       = sel_ff;
      k_in         = k_ff;
      red_in       = red_ff;
      neg_in       = neg_ff;
      quat_in      = quat_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      yaw_in       = yaw_ff;
      it_in        = it_ff;
      prod_in      = mul_a * mul_b;
      s1_in = s1_ff; c1_in = c1_ff; s2_in = s2_ff; c2_in = c2_ff;
      sd_in = sd_ff; cd_in = cd_ff; t_in = t_ff; ya_in = ya_ff; xa_in = xa_ff;
      m3_in        = m3_ff;
      rsp_valid_in = rsp_valid_ff;
      heading_in   = heading_ff;
      qz_in        = qz_ff;
      qw_in        = qw_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.start_of_route || !have_prev_ff) begin
                  // first waypoint of a route only gets stored
                  prev_lat_in  = req_chan.latitude;
                  prev_lon_in  = req_chan.longitude;
                  have_prev_in = 1'b1;
               end else begin
                  cur_lat_in = req_chan.latitude;
                  cur_lon_in = req_chan.longitude;
                  sel_in     = SEL_LAT1;
                  state_in   = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            // bias negatives up so the reduction works on a non-negative value
            red_in   = d_ext[RED_W-1] ? d_ext + RED_OFS : d_ext;
            k_in     = 4'(RED_K);
            state_in = S_RED;
         end
         S_RED: begin
            // restoring reduction modulo a full turn, one multiple per cycle
            if (red_ff >= red_step) red_in = red_ff - red_step;
            if (k_ff == 4'd0) state_in = S_FOLD;
            else k_in = k_ff - 4'd1;
         end
         S_FOLD: begin
            // fold into +-90 degrees, remembering the sign flip
            if (fr > QUARTER_R) begin
               red_in = fr - HALF_R;
               neg_in = 1'b1;
            end else if (fr < -QUARTER_R) begin
               red_in = fr + HALF_R;
               neg_in = 1'b1;
            end else begin
               red_in = fr;
               neg_in = 1'b0;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_RINIT;
         end
         S_RINIT: begin
            z_in     = Z_W'((prod_ff + DEG_RND) >>> (ANGLE_FRACTION_BITS + 2));
            x_in     = GAIN_Q30;
            y_in     = '0;
            it_in    = '0;
            quat_in  = 1'b0;
            state_in = S_ROT;
         end
         S_ROT, S_VEC: begin
            x_in = nx;
            y_in = ny;
            z_in = nz;
            if (it_ff == IT_LAST) begin
               state_in = (state_ff == S_VEC) ? S_QINIT : S_STORE;
            end else begin
               it_in = it_ff + IT_W'(1);
            end
         end
         S_STORE: begin
            if (quat_ff) begin
               heading_in   = HEAD_W'(head_r);
               qz_in        = QUAT_W'(zs);
               qw_in        = QUAT_W'(ws);
               rsp_valid_in = 1'b1;
               prev_lat_in  = cur_lat_ff;
               prev_lon_in  = cur_lon_ff;
               state_in     = S_OUT;
            end else begin
               case (sel_ff)
                  SEL_LAT1: begin
                     s1_in = SC_W'(sv);
                     c1_in = SC_W'(cv);
                  end
                  SEL_LAT2: begin
                     s2_in = SC_W'(sv);
                     c2_in = SC_W'(cv);
                  end
                  default: begin
                     sd_in = SC_W'(sv);
                     cd_in = SC_W'(cv);
                  end
               endcase
               if (sel_ff == SEL_DLON) begin
                  state_in = S_P0;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = S_LOAD;
               end
            end
         end
         S_P0: state_in = S_P1;
         S_P1: begin
            ya_in    = SC_W'((prod_ff + P_W'(64'sd536870912)) >>> 30);
            state_in = S_P2;
         end
         S_P2: begin
            t_in     = SC_W'((prod_ff + P_W'(64'sd536870912)) >>> 30);
            state_in = S_P3;
         end
         S_P3: begin
            m3_in    = prod_ff;
            state_in = S_P4;
         end
         S_P4: begin
            xa_in    = SC_W'((xdiff + (P_W+1)'(64'sd536870912)) >>> 30);
            state_in = S_VINIT;
         end
         S_VINIT: begin
            it_in = '0;
            if (xa_ff == '0 && ya_ff == '0) begin
               // same or antipodal points: zero bearing
               z_in     = '0;
               state_in = S_QINIT;
            end else begin
               if (xa_ff[SC_W-1]) begin
                  x_in = -(XY_W'(xa_ff) <<< 28);
                  y_in = -(XY_W'(ya_ff) <<< 28);
                  z_in = ya_ff[SC_W-1] ? -PI_Q30 : PI_Q30;
               end else begin
                  x_in = XY_W'(xa_ff) <<< 28;
                  y_in = XY_W'(ya_ff) <<< 28;
                  z_in = '0;
               end
               state_in = S_VEC;
            end
         end
         S_QINIT: begin
            yaw_in   = ysat;
            z_in     = ysat >>> 1;
            x_in     = GAIN_Q30;
            y_in     = '0;
            it_in    = '0;
            neg_in   = 1'b0;
            quat_in  = 1'b1;
            state_in = S_ROT;
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         prev_lat_ff  <= '0;
         prev_lon_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_lat_ff  <= prev_lat_in;
         prev_lon_ff  <= prev_lon_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      cur_lat_ff <= cur_lat_in;
      cur_lon_ff <= cur_lon_in;
      sel_ff     <= sel_in;
      k_ff       <= k_in;
      red_ff     <= red_in;
      neg_ff     <= neg_in;
      quat_ff    <= quat_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      yaw_ff     <= yaw_in;
      it_ff      <= it_in;
      prod_ff    <= prod_in;
      s1_ff <= s1_in; c1_ff <= c1_in; s2_ff <= s2_in; c2_ff <= c2_in;
      sd_ff <= sd_in; cd_ff <= cd_in; t_ff <= t_in; ya_ff <= ya_in; xa_ff <= xa_in;
      m3_ff      <= m3_in;
      heading_ff <= heading_in;
      qz_ff      <= qz_in;
      qw_ff      <= qw_in;
   end

   a_valid_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_OUT)
      else $error("rsp valid outside output state");

   a_start_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.start_of_route) |=> state_ff == S_IDLE && !rsp_valid_ff)
      else $error("route start beat began a computation");

   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(qz_ff) <= 32'sd1073741824 && $signed(qz_ff) >= -32'sd1073741824
                        && $signed(qw_ff) <= 32'sd1073741824
                        && $signed(qw_ff) >= -32'sd1073741824))
      else $error("quaternion component out of range");

   a_prev_on_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> prev_lat_ff == cur_lat_ff && prev_lon_ff == cur_lon_ff)
      else $error("stored waypoint not advanced with result");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
   import rhq_pkg::*;

   localparam int ITER       = 32;
   localparam int FRAC       = 20;
   localparam int LAT_MAX    = 94371840;
   localparam int LON_MAX    = 188743680;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN      = 300;

   typedef struct packed {
      head_type heading;
      quat_type quat_z;
      quat_type quat_w;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rhq_req_if req_chan();
   rhq_rsp_if rsp_chan();

   route_heading_quaternion_top #(
      .CORDIC_ITERATIONS(ITER),
      .ANGLE_FRACTION_BITS(FRAC)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: the stored waypoint
   longint     last_lat;
   longint     last_lon;
   bit         have_last;
   result_type expected_headings[$];
   int         mismatch_count;
   int         idle_cycles;
   int         hold_off;
   int         rsp_wait;
   bit         rsp_paced;

   function automatic longint shr_floor(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint atan_step(int i);
      return longint'(step_angle(6'(i)));
   endfunction

   task automatic cordic_rotate(input longint ang, output longint s, output longint c);
      longint x, y, dx, dy;
      x = 652032874;
      y = 0;
      for (int i = 0; i < ITER; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (ang >= 0) begin
            x -= dx; y += dy; ang -= atan_step(i);
         end else begin
            x += dx; y -= dy; ang += atan_step(i);
         end
      end
      s = y;
      c = x;
   endtask

   task automatic degree_sincos(input longint d, output longint s, output longint c);
      longint half, full, quarter, r;
      bit flip;
      half = longint'(180) <<< FRAC;
      full = 2 * half;
      quarter = half / 2;
      r = d % full;
      flip = 0;
      if (r < 0) r += full;
      if (r >= half) r -= full;
      if (r > quarter) begin
         r -= half; flip = 1;
      end else if (r < -quarter) begin
         r += half; flip = 1;
      end
      cordic_rotate(round_shift(r * 74961321, FRAC + 2), s, c);
      if (flip) begin
         s = -s;
         c = -c;
      end
   endtask

   function automatic longint cordic_atan2(longint y, longint x);
      longint z, dx, dy, pi_q30;
      pi_q30 = longint'(PI_Q30);
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * (longint'(1) <<< 28);
      y = y * (longint'(1) <<< 28);
      if (x < 0) begin
         z = (y >= 0) ? pi_q30 : -pi_q30;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < ITER; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_step(i);
         end else begin
            x -= dx; y += dy; z -= atan_step(i);
         end
      end
      return z;
   endfunction

   // works out the heading for one accepted waypoint, if it gives one
   task automatic predict_heading(input bit route_start, input lat_type lat, input lon_type lon);
      longint s1, c1, s2, c2, sd, cd, y, x, yaw, qz, qw;
      result_type h;
      if (route_start || !have_last) begin
         last_lat = lat;
         last_lon = lon;
         have_last = 1;
         return;
      end
      degree_sincos(last_lat, s1, c1);
      degree_sincos(longint'(lat), s2, c2);
      degree_sincos(longint'(lon) - last_lon, sd, cd);
      y = round_shift(sd * c2, 30);
      x = round_shift(c1 * s2 - round_shift(s1 * c2, 30) * cd, 30);
      yaw = clamp(cordic_atan2(y, x), longint'(PI_Q30));
      cordic_rotate(shr_floor(yaw, 1), qz, qw);
      h.heading = head_type'(round_shift(yaw, 2));
      h.quat_z = quat_type'(clamp(qz, 1073741824));
      h.quat_w = quat_type'(clamp(qw, 1073741824));
      expected_headings.insert(expected_headings.size(), h);
      last_lat = lat;
      last_lon = lon;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.start_of_route = 1'b0;
      req_chan.latitude = '0;
      req_chan.longitude = '0;
      rsp_chan.ready = 1'b0;
   end

   // result side: a randomly drawn wait per beat when paced, or a long hold-off when asked
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_wait <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         draw = rsp_paced ? $urandom_range(0, 5) : 0;
         rsp_wait <= draw;
         rsp_chan.ready <= (draw == 0);
      end else if (rsp_chan.valid && rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_chan.ready <= (rsp_wait == 1);
      end else if (rsp_wait == 0) begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // checks each result beat against the oldest expected heading
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_headings.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            want = expected_headings.pop_front();
            if (rsp_chan.heading !== want.heading)
               report_mismatch("heading", rsp_chan.heading, want.heading);
            if (rsp_chan.quat_z !== want.quat_z)
               report_mismatch("quat_z", rsp_chan.quat_z, want.quat_z);
            if (rsp_chan.quat_w !== want.quat_w)
               report_mismatch("quat_w", rsp_chan.quat_w, want.quat_w);
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** route_heading_quaternion_top: FAILED **");
         $finish;
      end
   end

   // sends one waypoint beat, with a random gap before it when paced
   task automatic send_waypoint(input bit route_start, input longint lat, input longint lon,
                                input bit paced = 1);
      int gap;
      gap = paced ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.start_of_route <= route_start;
      req_chan.latitude <= lat_type'(lat);
      req_chan.longitude <= lon_type'(lon);
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_heading(route_start, lat_type'(lat), lon_type'(lon));
   endtask

   task automatic wait_for_headings();
      req_chan.valid <= 1'b0;
      while (expected_headings.size() != 0) @(posedge clock);
   endtask

   function automatic longint any_lat();
      return longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
   endfunction

   function automatic longint any_lon();
      return longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
   endfunction

   // extremes, poles, same and antipodal points, missing route start
   task automatic test_directed();
      // first beat after reset without a route start only stores the point
      send_waypoint(0, 0, 0);
      send_waypoint(0, 0, 0);                       // same point: both terms zero
      send_waypoint(0, 0, LON_MAX);                 // antipodal on the equator
      send_waypoint(0, LAT_MAX, LON_MAX);           // north pole
      send_waypoint(0, -LAT_MAX, -LON_MAX);         // south pole
      send_waypoint(0, LAT_MAX, 0);
      send_waypoint(1, -LAT_MAX, LON_MAX);
      send_waypoint(0, LAT_MAX, -LON_MAX);
      send_waypoint(0, 10 << FRAC, 20 << FRAC);
      send_waypoint(0, 10 << FRAC, 19 << FRAC);     // due west
      send_waypoint(0, 9 << FRAC, 19 << FRAC);      // due south
      send_waypoint(0, 9 << FRAC, 19 << FRAC);
      send_waypoint(1, 0, 179 << FRAC);
      send_waypoint(0, 0, -179 << FRAC);            // across the date line
      // out of range and full-width field values, every bit toggled
      send_waypoint(0, -(1 << 27), -(1 << 28));
      send_waypoint(0, (1 << 27) - 1, (1 << 28) - 1);
      send_waypoint(0, 1, 1);
      send_waypoint(0, -1, -1);
      send_waypoint(0, 45 << FRAC, 90 << FRAC);
      send_waypoint(0, -45 << FRAC, -90 << FRAC);
      wait_for_headings();
   endtask

   // routes of random length with random points, some noise beats
   task automatic test_random_routes(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 8);
         send_waypoint(1, any_lat(), any_lon());
         sent++;
         for (int k = 0; k < len && sent < count; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_waypoint(0, $signed($urandom()) >>> 4, $signed($urandom()) >>> 3);
            else if ($urandom_range(0, 4) == 0)
               send_waypoint(0, any_lat() >>> 6, any_lon() >>> 6);   // points near zero latitude and longitude
            else
               send_waypoint(0, any_lat(), any_lon());
            sent++;
         end
      end
      wait_for_headings();
   endtask

   // results held back a long while as the sender keeps offering
   task automatic test_backpressure();
      hold_off = 1500;
      send_waypoint(1, any_lat(), any_lon(), 0);
      for (int k = 0; k < 6; k++)
         send_waypoint(0, any_lat(), any_lon(), 0);
      wait_for_headings();
   endtask

   // back-to-back beats with the receiver always ready
   task automatic test_full_rate();
      rsp_paced = 0;
      send_waypoint(1, any_lat(), any_lon(), 0);
      for (int k = 0; k < 20; k++)
         send_waypoint(0, any_lat(), any_lon(), 0);
      wait_for_headings();
      rsp_paced = 1;
   endtask

   initial begin
      mismatch_count = 0;
      idle_cycles = 0;
      hold_off = 0;
      rsp_paced = 1;
      have_last = 0;
      last_lat = 0;
      last_lon = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random_routes(600);
      test_full_rate();

      repeat (DRAIN) @(posedge clock);
      if (mismatch_count == 0 && expected_headings.size() == 0) begin
         $display("** route_heading_quaternion_top: PASSED **");
      end else begin
         if (expected_headings.size() != 0)
            $display("%0d headings never arrived", expected_headings.size());
         $display("** route_heading_quaternion_top: FAILED **");
      end
      $finish;
   end

endmodule
